// ----- hw/rtl/chd_pkg.sv -----
package chd_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int CHAIN_DEPTH_DEF = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KEY_WIDTH   = 64;
  localparam int CFG_WIDTH   = 7;
  localparam int COUNT_WIDTH = 10;

  localparam logic [CFG_WIDTH-1:0] BUCKET_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_PUT     = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_LEN,
    B_SCAN,
    B_ACT,
    B_SHIFT_RD,
    B_SHIFT_WR,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_status_t;

endpackage

// ----- hw/rtl/chd_ram.sv -----
module chd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/chd_queue.sv -----
module chd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        slots[wptr] <= wdata;
        wptr        <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ----- hw/rtl/chd_front.sv -----
module chd_front import chd_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  localparam int EW = 2 + KEY_WIDTH + VALUE_WIDTH + BW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_push,
  input  logic [1:0]             in_action,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   busy,
  input  logic [CFG_WIDTH-1:0]   bucket_count,
  output logic                   q_push,
  output logic [EW-1:0]          q_data,
  input  logic                   q_full
);

  front_state_t           state;
  front_state_t           state_next;
  logic [1:0]             action;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;
  logic [CFG_WIDTH-1:0]   rem;
  logic [5:0]             bit_idx;
  logic [CFG_WIDTH-1:0]   n_eff;
  logic [CFG_WIDTH:0]     trial;

  always_comb begin
    if (bucket_count == '0) begin
      n_eff = CFG_WIDTH'(1);
    end else if (32'(bucket_count) > MAX_BUCKETS) begin
      n_eff = CFG_WIDTH'(MAX_BUCKETS);
    end else begin
      n_eff = bucket_count;
    end
  end

  // one restoring step of key mod n per cycle, MSB first
  assign trial = {rem, key[bit_idx]};

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH);
  assign q_data = {action, key, value, BW'(rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_push) state_next = F_DIV;
      F_DIV:  if (bit_idx == 6'd0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_push) begin
          action  <= in_action;
          key     <= in_key;
          value   <= in_value;
          rem     <= '0;
          bit_idx <= 6'd63;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, n_eff}) begin
          rem <= CFG_WIDTH'(trial - {1'b0, n_eff});
        end else begin
          rem <= CFG_WIDTH'(trial);
        end
        bit_idx <= bit_idx - 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/chd_back.sv -----
module chd_back import chd_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  localparam int LW = $clog2(CHAIN_DEPTH + 1),
  localparam int SLOTS = MAX_BUCKETS * CHAIN_DEPTH,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int EW = 2 + KEY_WIDTH + VALUE_WIDTH + BW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [EW-1:0]          q_data,
  input  logic                   q_empty,
  output logic                   q_pop,
  output back_status_t           stat,
  output logic                   res_valid,
  input  logic                   res_pop,
  output logic [1:0]             res_status,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic [COUNT_WIDTH-1:0] res_total
);

  back_state_t            state;
  back_state_t            state_next;
  logic [1:0]             action;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;
  logic [BW-1:0]          bucket;
  logic [AW-1:0]          base;
  logic [LW-1:0]          len;
  logic [LW-1:0]          idx;
  logic                   found;
  logic [BW-1:0]          clr_idx;
  logic [COUNT_WIDTH-1:0] count;
  logic [1:0]             st;
  logic [VALUE_WIDTH-1:0] result;

  logic [KEY_WIDTH-1:0]   q_key;
  logic [BW-1:0]          q_bucket;

  logic                   len_we;
  logic [BW-1:0]          len_waddr;
  logic [LW-1:0]          len_wdata;
  logic [BW-1:0]          len_raddr;
  logic [LW-1:0]          len_rdata;
  logic                   key_we;
  logic                   val_we;
  logic [AW-1:0]          slot_waddr;
  logic [KEY_WIDTH-1:0]   key_wdata;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [AW-1:0]          slot_raddr;
  logic [KEY_WIDTH-1:0]   key_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   hit;
  logic                   last_scan;
  logic                   more_shift;

  assign q_key    = q_data[EW-3 -: KEY_WIDTH];
  assign q_bucket = q_data[BW-1:0];

  assign hit        = (key_rdata == key);
  assign last_scan  = (LW'(idx + LW'(1)) == len);
  assign more_shift = ({1'b0, idx} + (LW+1)'(2)) < {1'b0, len};

  assign q_pop         = (state == B_IDLE) && !q_empty;
  assign stat.clearing = (state == B_CLEAR);
  assign stat.idle     = (state == B_IDLE);
  assign len_raddr     = q_bucket;

  always_comb begin
    if (state == B_SCAN || state == B_SHIFT_RD) begin
      slot_raddr = base + AW'(idx) + AW'(1);
    end else begin
      slot_raddr = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    len_we     = 1'b0;
    len_waddr  = bucket;
    len_wdata  = '0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    slot_waddr = base + AW'(idx);
    key_wdata  = key_rdata;
    val_wdata  = val_rdata;
    unique case (state)
      B_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_idx;
        if (clr_idx == BW'(MAX_BUCKETS - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) state_next = B_LEN;
      end
      B_LEN: begin
        state_next = (len_rdata == '0) ? B_ACT : B_SCAN;
      end
      B_SCAN: begin
        if (hit || last_scan) state_next = B_ACT;
      end
      B_ACT: begin
        state_next = B_DONE;
        unique case (action)
          ACT_PUT: begin
            if (!found && len != LW'(CHAIN_DEPTH)) begin
              key_we     = 1'b1;
              val_we     = 1'b1;
              slot_waddr = base + AW'(len);
              key_wdata  = key;
              val_wdata  = value;
              len_we     = 1'b1;
              len_wdata  = len + LW'(1);
            end
          end
          ACT_REPLACE: begin
            if (found) begin
              val_we    = 1'b1;
              val_wdata = value;
            end
          end
          ACT_REMOVE: begin
            if (found) begin
              len_we    = 1'b1;
              len_wdata = len - LW'(1);
              if (!last_scan) state_next = B_SHIFT_RD;
            end
          end
          default: begin
          end
        endcase
      end
      B_SHIFT_RD: begin
        state_next = B_SHIFT_WR;
      end
      B_SHIFT_WR: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        state_next = more_shift ? B_SHIFT_RD : B_DONE;
      end
      B_DONE: begin
        if (!res_valid || res_pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == B_DONE && (!res_valid || res_pop)) begin
        res_valid <= 1'b1;
      end else if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: clr_idx <= clr_idx + BW'(1);
        B_IDLE: begin
          if (!q_empty) begin
            action <= q_data[EW-1 -: 2];
            key    <= q_key;
            value  <= q_data[BW +: VALUE_WIDTH];
            bucket <= q_bucket;
            base   <= AW'(32'(q_bucket) * CHAIN_DEPTH);
          end
        end
        B_LEN: begin
          len   <= len_rdata;
          idx   <= '0;
          found <= 1'b0;
        end
        B_SCAN: begin
          if (hit) begin
            found  <= 1'b1;
            result <= val_rdata;
          end else if (!last_scan) begin
            idx <= idx + LW'(1);
          end
        end
        B_ACT: begin
          st <= ST_OK;
          unique case (action)
            ACT_PUT: begin
              result <= '0;
              if (found) begin
                st <= ST_DUP;
              end else if (len == LW'(CHAIN_DEPTH)) begin
                st <= ST_FULL;
              end else begin
                count <= count + COUNT_WIDTH'(1);
              end
            end
            ACT_REMOVE: begin
              if (!found) begin
                st     <= ST_MISSING;
                result <= '0;
              end else begin
                count <= count - COUNT_WIDTH'(1);
              end
            end
            default: begin
              if (!found) begin
                st     <= ST_MISSING;
                result <= '0;
              end
            end
          endcase
        end
        B_SHIFT_WR: idx <= idx + LW'(1);
        B_DONE: begin
          if (!res_valid || res_pop) begin
            res_status <= st;
            res_value  <= result;
            res_total  <= count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  chd_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  chd_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_waddr),
    .wdata (key_wdata),
    .raddr (slot_raddr),
    .rdata (key_rdata)
  );

  chd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_waddr),
    .wdata (val_wdata),
    .raddr (slot_raddr),
    .rdata (val_rdata)
  );

`ifndef SYNTHESIS
  a_count_from_act: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(count)) |-> ($past(state) == B_ACT))
    else $error("element count moved outside an operation");

  a_scan_in_chain: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (idx < len))
    else $error("chain scan ran past chain length");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $rose(res_valid)) |-> ($past(state) == B_DONE))
    else $error("result appeared without a finished operation");
`endif

endmodule

// ----- hw/rtl/chained_hash_table_top.sv -----
// A remove that finds its key shifts each later entry of the chain down one slot.
// The sustained rate is set by the bit-serial 64-bit modulo, which reduces one key at
//   a time; the chain walk overlaps the next key's modulo through the two-entry queue.
// Reset (rst, synchronous): clears the element count and runs a clearing pass over
//   the chain lengths, holding full high until it ends.
module chained_hash_table_top import chd_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input queue side
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             action,
  input  logic [KEY_WIDTH-1:0]   key_in,
  input  logic [VALUE_WIDTH-1:0] value_in,
  // result queue side
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] value_out,
  output logic [COUNT_WIDTH-1:0] element_total,
  // bucket count register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_WIDTH-1:0]   cfg_data
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int EW = 2 + KEY_WIDTH + VALUE_WIDTH + BW;

  logic [CFG_WIDTH-1:0] bucket_count;
  logic                 front_busy;
  logic                 fq_push;
  logic [EW-1:0]        fq_wdata;
  logic                 fq_full;
  logic                 fq_pop;
  logic [EW-1:0]        fq_rdata;
  logic                 fq_empty;
  logic                 res_valid;
  back_status_t         back_stat;

  // The user must write the register only while idle; the block does not enforce it and always takes the transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  // Hold off new items while the modulo runs or waits to enter the queue, or the chain lengths are being cleared.
  assign full  = front_busy || back_stat.clearing;
  assign empty = !res_valid;

  // Front: accept an item and reduce its key to a bucket number.
  chd_front #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_push      (push && !full),
    .in_action    (action),
    .in_key       (key_in),
    .in_value     (value_in),
    .busy         (front_busy),
    .bucket_count (bucket_count),
    .q_push       (fq_push),
    .q_data       (fq_wdata),
    .q_full       (fq_full)
  );

  // Decouple the modulo from the chain walk.
  chd_queue #(.WIDTH(EW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Back: walk the chain, apply the operation, and drive the result register.
  chd_back #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (fq_rdata),
    .q_empty    (fq_empty),
    .q_pop      (fq_pop),
    .stat       (back_stat),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_status (status),
    .res_value  (value_out),
    .res_total  (element_total)
  );

endmodule

// ----- bench/chained_hash_table_top_tb.sv -----
module chained_hash_table_top_tb;
  import chd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB  = MAX_BUCKETS_DEF;
  localparam int CD  = CHAIN_DEPTH_DEF;
  localparam int VW  = VALUE_WIDTH_DEF;
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  // Settle time after the last result before a register write or the end:
  // worst latency of one operation, remove shuffle included, with margin.
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    status_t             st;
    logic [VW-1:0]       value;
    logic [COUNT_WIDTH-1:0] total;
  } outcome_t;

  typedef struct {
    action_t             act;
    logic [KEY_WIDTH-1:0] key;
    logic [VW-1:0]       value;
    bit                  typed;    // expected outcome typed in below
    status_t             st;
    logic [VW-1:0]       vout;
    logic [COUNT_WIDTH-1:0] total;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [1:0]             action;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [VW-1:0]          value_in;
  logic                   empty;
  logic                   pop;
  logic [1:0]             status;
  logic [VW-1:0]          value_out;
  logic [COUNT_WIDTH-1:0] element_total;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_WIDTH-1:0]   cfg_data;

  chained_hash_table_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .action(action), .key_in(key_in), .value_in(value_in),
    .empty(empty), .pop(pop), .status(status), .value_out(value_out),
    .element_total(element_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the table: stores, chain lengths, count and bucket register.
  logic [KEY_WIDTH-1:0]   shadow_keys [NB*CD];
  logic [VW-1:0]          shadow_vals [NB*CD];
  int unsigned            shadow_len  [NB];
  logic [COUNT_WIDTH-1:0] shadow_count;
  logic [CFG_WIDTH-1:0]   shadow_buckets;

  outcome_t pending_results[$];
  int       err_cnt;
  int       sent_cnt;
  int       checked_cnt;
  int       tx_idle_pct;
  int       rx_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("chained_hash_table_top_tb: done, errors");
    $finish;
  end

  // Apply one operation to the shadow table and return what the block must report.
  function automatic outcome_t apply_hash_op(action_t act, logic [KEY_WIDTH-1:0] key,
                                             logic [VW-1:0] val);
    outcome_t r;
    int unsigned nb;
    int unsigned bkt;
    int unsigned base;
    int unsigned len;
    int pos;
    r.st    = ST_OK;
    r.value = '0;
    // Zero buckets acts as one; anything above the table size saturates.
    nb = (shadow_buckets == 0) ? 1 : (shadow_buckets > NB) ? NB : shadow_buckets;
    bkt  = int'(key % 64'(nb));
    base = bkt * CD;
    len  = (shadow_len[bkt] > CD) ? CD : shadow_len[bkt];
    pos  = -1;
    for (int i = 0; i < int'(len); i++) begin
      if (pos < 0 && shadow_keys[base+i] == key) pos = i;
    end
    case (act)
      ACT_PUT: begin
        // Duplicate test wins over the full test.
        if (pos >= 0) r.st = ST_DUP;
        else if (len >= CD) r.st = ST_FULL;
        else begin
          shadow_keys[base+len] = key;
          shadow_vals[base+len] = val;
          shadow_len[bkt] = len + 1;
          shadow_count++;
        end
      end
      ACT_LOOKUP: begin
        if (pos < 0) r.st = ST_MISSING;
        else r.value = shadow_vals[base+pos];
      end
      ACT_REPLACE: begin
        if (pos < 0) r.st = ST_MISSING;
        else begin
          r.value = shadow_vals[base+pos];
          shadow_vals[base+pos] = val;
        end
      end
      default: begin
        if (pos < 0) r.st = ST_MISSING;
        else begin
          r.value = shadow_vals[base+pos];
          // Close the gap so chain order is kept.
          for (int i = pos; i + 1 < int'(len); i++) begin
            shadow_keys[base+i] = shadow_keys[base+i+1];
            shadow_vals[base+i] = shadow_vals[base+i+1];
          end
          shadow_len[bkt] = len - 1;
          shadow_count--;
        end
      end
    endcase
    r.total = shadow_count;
    return r;
  endfunction

  // Present one item and hold it until the transfer; push stays high afterwards
  // so back-to-back items never drop it within a step.
  task automatic send_op(action_t act, logic [KEY_WIDTH-1:0] key, logic [VW-1:0] val,
                         output outcome_t predicted);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    action   <= act;
    key_in   <= key;
    value_in <= val;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    predicted = apply_hash_op(act, key, val);
    sent_cnt++;
  endtask

  task automatic idle_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the bucket count only once the block has gone quiet.
  task automatic write_buckets(logic [CFG_WIDTH-1:0] n);
    bit taken;
    push <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    shadow_buckets = n;
  endtask

  // Randomly stall the result side.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare at the falling edge: pop and the result ports are settled, and a
  // transfer happens at the next rising edge exactly when this test holds.
  always @(negedge clk) begin
    outcome_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status=%0d value_out=%h total=%0d",
               status, value_out, element_total);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_cnt++;
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          err_cnt++;
        end
        if (value_out !== exp_r.value) begin
          $error("value_out: expected %h, got %h", exp_r.value, value_out);
          err_cnt++;
        end
        if (element_total !== exp_r.total) begin
          $error("element_total: expected %0d, got %0d", exp_r.total, element_total);
          err_cnt++;
        end
      end
    end
  end

  // Directed rows run with 64 buckets. Keys that are multiples of 64 all land in
  // bucket 0, which fills the chain, trips the full case and exercises the shuffle.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ACT_LOOKUP,  64'd0,       32'd0,          1, ST_MISSING, 32'd0,          10'd0},
    '{ACT_PUT,     '1,          32'hFFFF_FFFF,  1, ST_OK,      32'd0,          10'd1},
    '{ACT_PUT,     '1,          32'd0,          1, ST_DUP,     32'd0,          10'd1},
    '{ACT_LOOKUP,  '1,          32'd0,          1, ST_OK,      32'hFFFF_FFFF,  10'd1},
    '{ACT_REPLACE, '1,          32'd0,          1, ST_OK,      32'hFFFF_FFFF,  10'd1},
    '{ACT_REPLACE, 64'd1,       32'h1234_5678,  1, ST_MISSING, 32'd0,          10'd1},
    '{ACT_REMOVE,  '1,          32'd0,          1, ST_OK,      32'd0,          10'd0},
    '{ACT_REMOVE,  '1,          32'd0,          1, ST_MISSING, 32'd0,          10'd0},
    '{ACT_PUT,     64'd0,       32'd1,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd64,      32'd2,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd128,     32'd3,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd192,     32'd4,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd256,     32'd5,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd320,     32'd6,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd384,     32'd7,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd448,     32'd8,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd512,     32'd9,          1, ST_FULL,    32'd0,          10'd8},
    '{ACT_REMOVE,  64'd192,     32'd0,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_LOOKUP,  64'd448,     32'd0,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_PUT,     64'd512,     32'hA5A5_A5A5,  0, ST_OK,      32'd0,          10'd0},
    '{ACT_REMOVE,  64'd0,       32'd0,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_LOOKUP,  64'd512,     32'd0,          0, ST_OK,      32'd0,          10'd0},
    '{ACT_LOOKUP,  64'h8000_0000_0000_0000, 32'd0, 0, ST_OK,  32'd0,          10'd0}
  };

  initial begin
    outcome_t predicted;
    logic [KEY_WIDTH-1:0] key_pool [12];
    logic [CFG_WIDTH-1:0] phase_buckets [RANDOM_PHASES];
    logic [KEY_WIDTH-1:0] k;
    action_t act;
    int pick;

    rst       = 1'b1;
    push      = 1'b0;
    action    = ACT_PUT;
    key_in    = '0;
    value_in  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    err_cnt = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < NB; i++) shadow_len[i] = 0;
    shadow_count   = '0;
    shadow_buckets = BUCKET_COUNT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: the block holds full high during its clearing pass, and
    // the handshake simply waits it out.
    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].act, directed_rows[i].key, directed_rows[i].value, predicted);
      if (directed_rows[i].typed) begin
        predicted.st    = directed_rows[i].st;
        predicted.value = directed_rows[i].vout;
        predicted.total = directed_rows[i].total;
      end
      pending_results.push_back(predicted);
    end

    // Random phases; bucket counts cover one, the top, zero (treated as one),
    // an over-range value (saturates) and odd sizes. Entries left over from a
    // previous setting stay put without rehash, so stale hits are exercised.
    phase_buckets = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'($urandom_range(1, 127))};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_buckets(phase_buckets[ph]);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      // A small key pool keeps chains hit often; some keys are fully random.
      foreach (key_pool[i]) begin
        if (i < 6) key_pool[i] = {$urandom, $urandom};
        else key_pool[i] = 64'($urandom_range(0, 255));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off once until the block has returned everything.
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) begin
          push <= 1'b0;
          drain_results();
        end
        pick = $urandom_range(99);
        act = (pick < 40) ? ACT_PUT : (pick < 60) ? ACT_LOOKUP :
              (pick < 80) ? ACT_REPLACE : ACT_REMOVE;
        if ($urandom_range(99) < 15) k = {$urandom, $urandom};
        else k = key_pool[$urandom_range(0, 11)];
        send_op(act, k, $urandom, predicted);
        pending_results.push_back(predicted);
      end
    end

    idle_push();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
    end

    $display("Ran %0d operations (directed corners plus random put/lookup/replace/remove)",
             sent_cnt);
    $display("over %0d bucket settings with idle and stall mixes; %0d results compared",
             RANDOM_PHASES + 1, checked_cnt);
    if (err_cnt == 0) begin
      $display("chained_hash_table_top_tb: done, clean");
    end else begin
      $display("chained_hash_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
